>>> sv/assert_macros.svh
// Assertion helpers shared by the digest RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/md4_pkg.sv
package md4_pkg;

  localparam logic [31:0] K2 = 32'h5a827999;
  localparam logic [31:0] K3 = 32'h6ed9eba1;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Message word index used by step i of the 48 steps.
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] j;
    j = i[3:0];
    if (i < 6'd16) return j;
    else if (i < 6'd32) return {j[1:0], j[3:2]};
    else return {j[0], j[1], j[2], j[3]};
  endfunction

  function automatic logic [4:0] shift_sel(input logic [5:0] i);
    logic [4:0] s;
    s = 5'd3;
    if (i < 6'd16) begin
      case (i[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd7;
        2'd2: s = 5'd11;
        default: s = 5'd19;
      endcase
    end else if (i < 6'd32) begin
      case (i[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd5;
        2'd2: s = 5'd9;
        default: s = 5'd13;
      endcase
    end else begin
      case (i[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd9;
        2'd2: s = 5'd11;
        default: s = 5'd15;
      endcase
    end
    return s;
  endfunction

endpackage

>>> sv/md4_message_digest.sv
// Channel  | Direction | Ports
// in       | input     | in_valid, in_stall, in_command, in_data_byte
// out      | output    | out_valid, out_stall, out_digest_word, out_word_index, out_last_word
//
// An absorb byte is written straight into the block memory; the 64th byte of a block
// then runs the first word fetch, the 48 round steps (one per cycle) and the chain add.
// A finish writes pad bytes one per cycle into the block memory (up to the end of the
// block, and over a whole second block when one is needed), compresses once or twice,
// then emits four words.
// The block memory is read one word per step; round steps set the pace.
// Reset (rst_n, synchronous, low) restores the initial chain words and a zero count.
// A stalled output holds its word; input is stalled whenever the block is busy.
`include "assert_macros.svh"
module md4_message_digest import md4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  // Block memory: sixteen words, byte write enables, registered read.
  logic [31:0] mem [16];
  logic [31:0] rd_r;
  logic [3:0]  wr_addr, rd_addr;
  logic [1:0]  wr_lane;
  logic [7:0]  wr_data;
  logic        wr_en;

  state_t      state_r, state_nxt;
  logic [60:0] count_r;
  logic [31:0] ch_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  step_r;
  logic [5:0]  pos_r;
  logic        last_blk_r;
  logic        fin_r;
  logic        mark_r;
  logic [1:0]  emit_r;
  logic [63:0] bits;

  logic acc;
  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign bits = {count_r, 3'b000};

  // Byte written at the current position during padding.
  logic [7:0] pad_byte;
  always_comb begin
    pad_byte = 8'h00;
    if (mark_r) pad_byte = PAD_BYTE;
    else if (last_blk_r && pos_r >= 6'd56) pad_byte = bits[{pos_r[2:0], 3'b000} +: 8];
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos_r[5:2];
    wr_lane = pos_r[1:0];
    wr_data = pad_byte;
    if (state_r == ST_IDLE && acc && in_command == CMD_ABSORB) begin
      wr_en = 1'b1;
      wr_data = in_data_byte;
      wr_addr = count_r[5:2];
      wr_lane = count_r[1:0];
    end else if (state_r == ST_PAD) begin
      wr_en = 1'b1;
    end
  end

  // Fetch the word for the next step ahead of it, so the registered read holds it when that step runs.
  assign rd_addr = word_sel(state_r == ST_LOAD ? 6'd0 : step_r + 6'd1);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // Step datapath.
  logic [31:0] f, kx, sum, rot;
  logic [4:0]  sh;
  always_comb begin
    if (step_r < 6'd16) begin
      f = (b_r & c_r) | (~b_r & d_r);
      kx = 32'd0;
    end else if (step_r < 6'd32) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      kx = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      kx = K3;
    end
    sh = shift_sel(step_r);
    sum = a_r + f + rd_r + kx;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (acc) begin
        if (in_command == CMD_FINISH) state_nxt = ST_PAD;
        else if (count_r[5:0] == 6'd63) state_nxt = ST_LOAD;
      end
      ST_PAD:   if (pos_r == 6'd63) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (step_r == 6'd47) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (last_blk_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT:  if (!out_stall && emit_r == 2'd3) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ch_r[0] <= IV0; ch_r[1] <= IV1; ch_r[2] <= IV2; ch_r[3] <= IV3;
      fin_r <= 1'b0;
      mark_r <= 1'b0;
      last_blk_r <= 1'b0;
      emit_r <= 2'd0;
      step_r <= 6'd0;
      pos_r <= 6'd0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (acc) begin
          if (in_command == CMD_FINISH) begin
            fin_r <= 1'b1;
            mark_r <= 1'b1;
            pos_r <= count_r[5:0];
            last_blk_r <= (count_r[5:0] < 6'd56);
          end else begin
            count_r <= count_r + 61'd1;
          end
        end
        ST_PAD: begin
          // In the first padding pass the first write is the 0x80 marker; the rest are zeros or length bytes.
          mark_r <= 1'b0;
          pos_r <= pos_r + 6'd1;
        end
        ST_LOAD: begin
          a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
          step_r <= 6'd0;
        end
        ST_ROUND: begin
          // Rotate roles: new value becomes b, old b..d shift toward a.
          a_r <= d_r; b_r <= rot; c_r <= b_r; d_r <= c_r;
          step_r <= step_r + 6'd1;
        end
        ST_ADD: begin
          ch_r[0] <= ch_r[0] + a_r; ch_r[1] <= ch_r[1] + b_r;
          ch_r[2] <= ch_r[2] + c_r; ch_r[3] <= ch_r[3] + d_r;
          pos_r <= 6'd0;
          last_blk_r <= 1'b1;
          emit_r <= 2'd0;
        end
        ST_EMIT: if (!out_stall) begin
          emit_r <= emit_r + 2'd1;
          if (emit_r == 2'd3) begin
            ch_r[0] <= IV0; ch_r[1] <= IV1; ch_r[2] <= IV2; ch_r[3] <= IV3;
            count_r <= '0;
            fin_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output drive.
  always_comb begin
    out_valid = (state_r == ST_EMIT);
    out_digest_word = ch_r[emit_r];
    out_word_index = emit_r;
    out_last_word = (emit_r == 2'd3);
  end

  `ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !acc, "accept while busy")
  `ASSERT_NEXT(a_round_len, clk, rst_n, state_r == ST_LOAD, state_r == ST_ROUND && step_r == 6'd0,
    "round did not start")
  `ASSERT_IMP(a_emit_fin, clk, rst_n, out_valid, fin_r && last_blk_r, "emit outside finish")
endmodule
